// ===== rtl/core/kch_pkg.sv =====
// Package for the k-mer counting hash table: sizes, codes, node word type.
// No dependencies; kch_mod_unit and the top level import it.
package kch_pkg;

   localparam int MAX_BUCKETS   = 4096;
   localparam int NODE_CAPACITY = 4096;
   localparam int COUNT_WIDTH   = 32;

   localparam int BUCKET_AW = $clog2(MAX_BUCKETS);
   localparam int NODE_AW   = $clog2(NODE_CAPACITY);
   // node reference: one bit more than the address, top bit set means no node
   localparam int NREF_W    = NODE_AW + 1;
   localparam int CFG_W     = 13;
   localparam int KEEP_W    = 8;
   localparam int KEY_W     = 64;
   localparam int DIV_CNT_W = $clog2(KEY_W);

   localparam logic [NREF_W-1:0]      NO_NODE     = {1'b1, {NODE_AW{1'b0}}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
   localparam logic [CFG_W-1:0]       MAX_BKT_CFG = CFG_W'(MAX_BUCKETS);
   localparam logic [CFG_W-1:0]       RST_BUCKETS = 13'd4093;
   localparam logic [KEEP_W-1:0]      RST_KEEP    = 8'd2;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_FILTER = 2'd2;

   localparam logic [2:0] STAT_NEW    = 3'd0;
   localparam logic [2:0] STAT_INCR   = 3'd1;
   localparam logic [2:0] STAT_FOUND  = 3'd2;
   localparam logic [2:0] STAT_MISS   = 3'd3;
   localparam logic [2:0] STAT_FULL   = 3'd4;
   localparam logic [2:0] STAT_FILTER = 3'd5;

   localparam logic CSR_BUCKET_COUNT = 1'b0;
   localparam logic CSR_MIN_KEEP     = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]       key_a;
      logic [KEY_W-1:0]       key_b;
      logic [KEY_W-1:0]       key_c;
      logic [COUNT_WIDTH-1:0] count;
      logic [NREF_W-1:0]      link;
   } node_type;

   localparam int NODE_WORD_W = $bits(node_type);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_HEAD_RD,
      S_HEAD_WAIT,
      S_NODE_CMP,
      S_FILT_HEAD,
      S_FILT_HWAIT,
      S_FILT_NODE,
      S_RESP
   } state_type;

endpackage

// ===== rtl/core/kch_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// Depends on nothing.
module kch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/kch_mod_unit.sv =====
// Bit-serial remainder unit: 64-bit dividend modulo a 13-bit divisor.
// Depends on kch_pkg.
module kch_mod_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [kch_pkg::KEY_W-1:0]      dividend,
   input  logic [kch_pkg::CFG_W-1:0]      divisor,
   output logic                           done,
   output logic [kch_pkg::BUCKET_AW-1:0]  remainder
);
   import kch_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0]     shift_ff, shift_in;
   logic [BUCKET_AW-1:0] rem_ff, rem_in;
   logic [CFG_W-1:0]     trial;
   logic [CFG_W-1:0]     diff;

   // one quotient bit per cycle, restoring form
   always_comb begin
      trial    = {rem_ff, shift_ff[KEY_W-1]};
      diff     = trial - divisor;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '1;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[KEY_W-2:0], 1'b0};
         rem_in   = (trial >= divisor) ? diff[BUCKET_AW-1:0] : trial[BUCKET_AW-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ===== rtl/core/kmer_count_hash_table.sv =====
// Top level of the k-mer counting hash table: control sequencer, CSRs,
// bucket head and node memories. Depends on kch_pkg, kch_ram, kch_mod_unit.
//
//  channel | role   | tdata (low bit up)          | tuser
//  req_    | input  | key_word_a, key_word_b, c   | action
//  rsp_    | output | key_count, entry_total, pad | status
//  csr_    | config | bucket_count @0, min_keep_count @4
//
// Insert/lookup: the key is hashed by the remainder steps of the mod unit,
// which then raises its done flag; the bucket head is read in S_HEAD_RD and
// S_HEAD_WAIT, each chain node visited is compared in S_NODE_CMP, and the
// result goes into the output register in S_RESP before the next request.
// Filter: each bucket head is read, then each of its chained nodes checked.
// After reset a clearing pass writes every bucket head empty, during which
// req_tready stays low; CSR writes are taken throughout.
// A result waits in the output register; the next request is accepted
// while it waits, and the sequencer stalls only if a second result is due.
module kmer_count_hash_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,  // key_word_a, key_word_b, key_word_c
   input  logic [1:0]   req_tuser,  // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // key_count, entry_total, zero pad
   output logic [2:0]   rsp_tuser,  // status
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import kch_pkg::*;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]       bucket_cfg_ff;
   logic [KEEP_W-1:0]      keep_cfg_ff;
   logic [CFG_W-1:0]       nb;
   logic                   csr_wr;

   logic [1:0]             action_ff, action_in;
   logic [KEY_W-1:0]       key_a_ff, key_b_ff, key_c_ff;
   logic [KEY_W-1:0]       key_a_in, key_b_in, key_c_in;
   logic [NREF_W-1:0]      cur_ff, cur_in;
   logic [NREF_W-1:0]      head_val_ff, head_val_in;
   logic [NODE_AW-1:0]     prev_ff, prev_in;
   logic                   prev_ok_ff, prev_ok_in;
   node_type               prev_word_ff, prev_word_in;
   logic [CFG_W-1:0]       scan_ff, scan_in;
   logic [NREF_W-1:0]      next_free_ff, next_free_in;
   logic [NREF_W-1:0]      entry_ff, entry_in;
   logic [BUCKET_AW-1:0]   clr_ff, clr_in;
   logic [2:0]             res_status_ff, res_status_in;
   logic [COUNT_WIDTH-1:0] res_count_ff, res_count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic [NREF_W-1:0]      rsp_entry_ff, rsp_entry_in;

   logic                   accept;
   logic                   out_free;
   logic                   do_miss;
   logic                   key_match;
   logic [COUNT_WIDTH-1:0] count_inc;

   logic                   div_start, div_done;
   logic [BUCKET_AW-1:0]   slot;

   logic                   head_rd_en, head_wr_en;
   logic [BUCKET_AW-1:0]   head_rd_addr, head_wr_addr;
   logic [NREF_W-1:0]      head_q, head_wr_data;

   logic                   node_rd_en, node_wr_en;
   logic [NODE_AW-1:0]     node_rd_addr, node_wr_addr;
   node_type               node_q, node_wr_word;
   logic [NODE_WORD_W-1:0] node_rd_bits;

   // ---------------------------------------------------------------- CSRs
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         CSR_BUCKET_COUNT: csr_prdata = {19'd0, bucket_cfg_ff};
         CSR_MIN_KEEP:     csr_prdata = {24'd0, keep_cfg_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // zero counts as one bucket, anything above the table size saturates
   assign nb = (bucket_cfg_ff == '0)        ? CFG_W'(1) :
               (bucket_cfg_ff > MAX_BKT_CFG) ? MAX_BKT_CFG : bucket_cfg_ff;

   // ---------------------------------------------------------------- units
   kch_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (key_a_in | key_b_in | key_c_in),
      .divisor   (nb),
      .done      (div_done),
      .remainder (slot)
   );

   kch_ram #(.WIDTH(NREF_W), .DEPTH(MAX_BUCKETS)) u_head_ram (
      .clock   (clock),
      .rd_en   (head_rd_en),
      .rd_addr (head_rd_addr),
      .rd_data (head_q),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data)
   );

   kch_ram #(.WIDTH(NODE_WORD_W), .DEPTH(NODE_CAPACITY)) u_node_ram (
      .clock   (clock),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_bits),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_word)
   );

   assign node_q = node_type'(node_rd_bits);

   // ---------------------------------------------------------------- control
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign key_match  = (node_q.key_a == key_a_ff) && (node_q.key_b == key_b_ff) &&
                       (node_q.key_c == key_c_ff);
   assign count_inc  = (node_q.count == COUNT_MAX) ? node_q.count
                                                   : node_q.count + 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:      if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == ACT_FILTER) ? S_FILT_HEAD : S_HASH;
            end
         end
         S_HASH:       if (div_done) state_in = S_HEAD_RD;
         S_HEAD_RD:    state_in = S_HEAD_WAIT;
         S_HEAD_WAIT:  state_in = head_q[NODE_AW] ? S_RESP : S_NODE_CMP;
         S_NODE_CMP: begin
            if (key_match || node_q.link[NODE_AW]) state_in = S_RESP;
         end
         S_FILT_HEAD:  state_in = (scan_ff >= nb) ? S_RESP : S_FILT_HWAIT;
         S_FILT_HWAIT: state_in = head_q[NODE_AW] ? S_FILT_HEAD : S_FILT_NODE;
         S_FILT_NODE:  if (node_q.link[NODE_AW]) state_in = S_FILT_HEAD;
         S_RESP:       if (out_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      action_in     = action_ff;
      key_a_in      = key_a_ff;
      key_b_in      = key_b_ff;
      key_c_in      = key_c_ff;
      cur_in        = cur_ff;
      head_val_in   = head_val_ff;
      prev_in       = prev_ff;
      prev_ok_in    = prev_ok_ff;
      prev_word_in  = prev_word_ff;
      scan_in       = scan_ff;
      next_free_in  = next_free_ff;
      entry_in      = entry_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      div_start     = 1'b0;
      do_miss       = 1'b0;
      head_rd_en    = 1'b0;
      head_rd_addr  = slot;
      head_wr_en    = 1'b0;
      head_wr_addr  = slot;
      head_wr_data  = NO_NODE;
      node_rd_en    = 1'b0;
      node_rd_addr  = cur_ff[NODE_AW-1:0];
      node_wr_en    = 1'b0;
      node_wr_addr  = cur_ff[NODE_AW-1:0];
      node_wr_word  = node_q;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_entry_in  = rsp_entry_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep every bucket head to empty
            head_wr_en   = 1'b1;
            head_wr_addr = clr_ff;
            clr_in       = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               action_in = req_tuser;
               key_a_in  = req_tdata[63:0];
               key_b_in  = req_tdata[127:64];
               key_c_in  = req_tdata[191:128];
               scan_in   = '0;
               div_start = (req_tuser != ACT_FILTER);
            end
         end
         S_HASH: begin
         end
         S_HEAD_RD: begin
            head_rd_en = 1'b1;
         end
         S_HEAD_WAIT: begin
            head_val_in = head_q;
            if (head_q[NODE_AW]) begin
               do_miss = 1'b1;
            end else begin
               node_rd_en   = 1'b1;
               node_rd_addr = head_q[NODE_AW-1:0];
               cur_in       = head_q;
            end
         end
         S_NODE_CMP: begin
            if (key_match) begin
               if (action_ff == ACT_INSERT) begin
                  node_wr_en         = 1'b1;
                  node_wr_word.count = count_inc;
                  res_count_in       = count_inc;
                  res_status_in      = STAT_INCR;
               end else begin
                  res_count_in  = node_q.count;
                  res_status_in = STAT_FOUND;
               end
            end else if (!node_q.link[NODE_AW]) begin
               node_rd_en   = 1'b1;
               node_rd_addr = node_q.link[NODE_AW-1:0];
               cur_in       = node_q.link;
            end else begin
               do_miss = 1'b1;
            end
         end
         S_FILT_HEAD: begin
            if (scan_ff >= nb) begin
               res_status_in = STAT_FILTER;
               res_count_in  = '0;
            end else begin
               head_rd_en   = 1'b1;
               head_rd_addr = scan_ff[BUCKET_AW-1:0];
            end
         end
         S_FILT_HWAIT: begin
            prev_ok_in = 1'b0;
            if (head_q[NODE_AW]) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               node_rd_en   = 1'b1;
               node_rd_addr = head_q[NODE_AW-1:0];
               cur_in       = head_q;
            end
         end
         S_FILT_NODE: begin
            if (node_q.count < COUNT_WIDTH'(keep_cfg_ff)) begin
               // unlink: patch the predecessor, or the head if there is none
               if (prev_ok_ff) begin
                  node_wr_en        = 1'b1;
                  node_wr_addr      = prev_ff;
                  node_wr_word      = prev_word_ff;
                  node_wr_word.link = node_q.link;
                  prev_word_in.link = node_q.link;
               end else begin
                  head_wr_en   = 1'b1;
                  head_wr_addr = scan_ff[BUCKET_AW-1:0];
                  head_wr_data = node_q.link;
               end
               if (entry_ff != '0) entry_in = entry_ff - 1'b1;
            end else begin
               prev_ok_in   = 1'b1;
               prev_in      = cur_ff[NODE_AW-1:0];
               prev_word_in = node_q;
            end
            if (node_q.link[NODE_AW]) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               node_rd_en   = 1'b1;
               node_rd_addr = node_q.link[NODE_AW-1:0];
               cur_in       = node_q.link;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = res_count_ff;
               rsp_entry_in  = entry_ff;
            end
         end
         default: begin
         end
      endcase

      // chain ended without a match
      if (do_miss) begin
         res_count_in = '0;
         if (action_ff != ACT_INSERT) begin
            res_status_in = STAT_MISS;
         end else if (next_free_ff[NODE_AW]) begin
            res_status_in = STAT_FULL;
         end else begin
            node_wr_en         = 1'b1;
            node_wr_addr       = next_free_ff[NODE_AW-1:0];
            node_wr_word.key_a = key_a_ff;
            node_wr_word.key_b = key_b_ff;
            node_wr_word.key_c = key_c_ff;
            node_wr_word.count = COUNT_WIDTH'(1);
            node_wr_word.link  = head_val_in;
            head_wr_en         = 1'b1;
            head_wr_addr       = slot;
            head_wr_data       = next_free_ff;
            next_free_in       = next_free_ff + 1'b1;
            entry_in           = entry_ff + 1'b1;
            res_count_in       = COUNT_WIDTH'(1);
            res_status_in      = STAT_NEW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         next_free_ff  <= '0;
         entry_ff      <= '0;
         bucket_cfg_ff <= RST_BUCKETS;
         keep_cfg_ff   <= RST_KEEP;
         rsp_valid_ff  <= 1'b0;
         prev_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         entry_ff     <= entry_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ok_ff   <= prev_ok_in;
         if (csr_wr && csr_paddr[2] == CSR_BUCKET_COUNT) begin
            bucket_cfg_ff <= csr_pwdata[CFG_W-1:0];
         end
         if (csr_wr && csr_paddr[2] == CSR_MIN_KEEP) begin
            keep_cfg_ff <= csr_pwdata[KEEP_W-1:0];
         end
      end
      action_ff     <= action_in;
      key_a_ff      <= key_a_in;
      key_b_ff      <= key_b_in;
      key_c_ff      <= key_c_in;
      cur_ff        <= cur_in;
      head_val_ff   <= head_val_in;
      prev_ff       <= prev_in;
      prev_word_ff  <= prev_word_in;
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'd0, rsp_entry_ff, rsp_count_ff};

   // ---------------------------------------------------------------- checks
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request accepted during head clearing");

   a_entries_le_alloc: assert property (@(posedge clock) disable iff (reset)
      entry_ff <= next_free_ff)
      else $error("entry count above allocated nodes");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second request taken while busy");

   a_walk_on_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NODE_CMP || state_ff == S_FILT_NODE) |-> !cur_ff[NODE_AW])
      else $error("chain walk on empty reference");

   a_resp_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !out_free) |=> (state_ff == S_RESP))
      else $error("result dropped while output busy");
endmodule
